FILE: rtl/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants of the fan PI regulator
// Field widths, register indexes and the divider request/response structs.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // Field widths
    localparam int DATA_W  = 16;   // temperature, target, drive level
    localparam int ERR_W   = 17;   // exact difference of two 16-bit values
    localparam int GAIN_W  = 8;
    localparam int TC_W    = 6;
    localparam int LEVEL_W = 10;
    localparam int ACC_W   = 15;   // stored integrator lies in 0 .. 32767
    localparam int CH_IN_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(ACC_W);

    // Integrator floor and ceiling scales
    localparam int INTEG_FLOOR_SCALE = 350;
    localparam int INTEG_CEIL_SCALE  = 1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN     = 3'd0,
        REG_TC       = 3'd1,
        REG_MAX_OUT  = 3'd2,
        REG_MIN_OUT  = 3'd3,
        REG_FULL_ON  = 3'd4,
        REG_FULL_OFF = 3'd5
    } cfg_reg_t;

    // Request to the shared divider
    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [TC_W-1:0]   divisor;
    } div_req_t;

    // Response of the shared divider
    typedef struct packed {
        logic              done;
        logic [ACC_W-1:0]  quotient;
    } div_rsp_t;

endpackage : fpr_pkg
`default_nettype wire

FILE: rtl/fpr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_div: iterative restoring divider
// Divides the integrator by the time constant, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpr_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fpr_pkg::div_req_t req,
    output fpr_pkg::div_rsp_t      rsp
);
    import fpr_pkg::*;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t           state_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TC_W-1:0]      rem_reg;
    logic [ACC_W-1:0]     quo_reg;
    logic [TC_W-1:0]      dsr_reg;
    logic                 done_reg;

    logic [TC_W:0]        shifted;
    logic                 fits;
    logic [TC_W:0]        diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        shifted = {rem_reg, quo_reg[ACC_W-1]};
        fits    = (shifted >= {1'b0, dsr_reg});
        diff    = shifted - {1'b0, dsr_reg};
    end

    // Sequence the steps and hold the partial remainder and quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= D_RUN;
                        cnt_reg   <= '0;
                    end
                end
                D_RUN:
                begin
                    if (cnt_reg == DIV_CNT_W'(ACC_W - 1))
                    begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    // Datapath: load operands, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (state_reg == D_RUN)
        begin
            rem_reg <= fits ? diff[TC_W-1:0] : shifted[TC_W-1:0];
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef NO_ASSERTIONS
    // A start is only issued to an idle divider
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == D_IDLE)
        else $error("divider started while busy");

    // Completion follows the last step and leaves the unit idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == D_IDLE && $past(state_reg == D_RUN))
        else $error("divider completion out of sequence");

    // The remainder stays below the divisor while running
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == D_RUN && cnt_reg != '0 |-> rem_reg < dsr_reg)
        else $error("divider remainder out of range");
`endif

endmodule : fpr_div
`default_nettype wire

FILE: rtl/fan_pi_regulator_clamped.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted item passes through accumulate, divide in the
//   bit-serial divider, sum and emit; a zero time constant skips the
//   divide step, and a channel of CHANNELS or more goes straight to emit.
// Items: a new item is accepted only after the last result is emitted.
// Reset: asynchronous, clears integrators to zero and loads register defaults.
// ----------------------------------------------------------------------------
// fan_pi_regulator_clamped: multi-channel PI fan regulator
// Per-channel integrator with floor and ceiling, gain term plus integrator
// over time constant, then full-on / full-off replacement of the drive.
// ----------------------------------------------------------------------------
module fan_pi_regulator_clamped #(
    parameter int CHANNELS = 3
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input item channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [fpr_pkg::CH_IN_W-1:0]        channel,
    input  wire logic signed [fpr_pkg::DATA_W-1:0]  temperature,
    input  wire logic signed [fpr_pkg::DATA_W-1:0]  target,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [fpr_pkg::DATA_W-1:0]       drive_level
);
    import fpr_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = GAIN_W + 1 + ERR_W;
    localparam int RAW_W  = PROD_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_SUM,
        S_EMIT
    } state_t;

    // Configuration registers
    logic [GAIN_W-1:0]  gain_reg;
    logic [TC_W-1:0]    tc_reg;
    logic [LEVEL_W-1:0] max_out_reg;
    logic [LEVEL_W-1:0] min_out_reg;
    logic [LEVEL_W-1:0] full_on_reg;
    logic [LEVEL_W-1:0] full_off_reg;

    // Channel state
    logic [ACC_W-1:0]   integ_reg [CHANNELS];

    // Sequencer and working registers
    state_t                   state_reg;
    logic [CH_W-1:0]          ch_idx_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]         quot_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] drive_out_reg;

    // Combinational signals
    logic [CH_W+1:0]          ch_wide;
    logic                     ch_ok;
    logic signed [ERR_W-1:0]  err_in;
    logic [ACC_W-1:0]         floor_v;
    logic [DATA_W-1:0]        ceil_v;
    logic signed [ERR_W:0]    acc_sum;
    logic signed [ERR_W:0]    acc_v;
    logic [ACC_W-1:0]         acc_new;
    logic signed [PROD_W-1:0] prod_v;
    logic signed [RAW_W-1:0]  raw_v;
    logic signed [DATA_W-1:0] sat_v;
    logic signed [DATA_W-1:0] over_v;
    logic signed [DATA_W-1:0] drive_v;
    logic                     emit_go;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign drive_level = drive_out_reg;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_W'(1);
            tc_reg       <= TC_W'(10);
            max_out_reg  <= LEVEL_W'(1000);
            min_out_reg  <= '0;
            full_on_reg  <= LEVEL_W'(1000);
            full_off_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN:     gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_TC:       tc_reg       <= cfg_data[TC_W-1:0];
                REG_MAX_OUT:  max_out_reg  <= cfg_data[LEVEL_W-1:0];
                REG_MIN_OUT:  min_out_reg  <= cfg_data[LEVEL_W-1:0];
                REG_FULL_ON:  full_on_reg  <= cfg_data[LEVEL_W-1:0];
                REG_FULL_OFF: full_off_reg <= cfg_data[LEVEL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Decode channel and form the exact error
    always_comb
    begin
        ch_wide = (CH_W + 2)'(channel);
        ch_ok   = (32'(channel) < CHANNELS);
        err_in  = ERR_W'(temperature) - ERR_W'(target);
    end

    // Integrator update: saturate, floor on positive error, clamp
    always_comb
    begin
        floor_v = ACC_W'(32'(INTEG_FLOOR_SCALE) * 32'(tc_reg));
        ceil_v  = DATA_W'(32'(INTEG_CEIL_SCALE) * 32'(tc_reg));
        acc_sum = $signed({3'b000, integ_reg[ch_idx_reg]}) + (ERR_W + 1)'(err_reg);
        if (acc_sum > $signed((ERR_W + 1)'(32767)))
        begin
            acc_v = (ERR_W + 1)'(32767);
        end
        else if (acc_sum < -$signed((ERR_W + 1)'(32768)))
        begin
            acc_v = -$signed((ERR_W + 1)'(32768));
        end
        else
        begin
            acc_v = acc_sum;
        end
        if (err_reg > 0 && acc_v < $signed({3'b000, floor_v}))
        begin
            acc_v = $signed({3'b000, floor_v});
        end
        if (acc_v > $signed({2'b00, ceil_v}))
        begin
            acc_v = $signed({2'b00, ceil_v});
        end
        if (acc_v < 0)
        begin
            acc_v = '0;
        end
        acc_new = acc_v[ACC_W-1:0];
        prod_v  = $signed({1'b0, gain_reg}) * err_reg;
    end

    // Sum, saturate and apply the full-on then full-off replacements
    always_comb
    begin
        raw_v = RAW_W'(prod_reg) + $signed(RAW_W'(quot_reg));
        if (raw_v > $signed(RAW_W'(32767)))
        begin
            sat_v = 16'sh7fff;
        end
        else if (raw_v < -$signed(RAW_W'(32768)))
        begin
            sat_v = 16'sh8000;
        end
        else
        begin
            sat_v = raw_v[DATA_W-1:0];
        end
        over_v  = (sat_v > $signed(DATA_W'(max_out_reg))) ?
                  $signed(DATA_W'(full_on_reg)) : sat_v;
        drive_v = (over_v < $signed(DATA_W'(min_out_reg))) ?
                  $signed(DATA_W'(full_off_reg)) : over_v;
    end

    // Issue the division once the integrator is settled
    always_comb
    begin
        div_req.start    = (state_reg == S_ACC) && (tc_reg != '0);
        div_req.dividend = acc_new;
        div_req.divisor  = tc_reg;
        emit_go          = !out_valid_reg || out_ready;
    end

    fpr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                integ_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ch_ok ? S_ACC : S_EMIT;
                    end
                end
                S_ACC:
                begin
                    integ_reg[ch_idx_reg] <= acc_new;
                    state_reg <= (tc_reg != '0) ? S_DIV : S_SUM;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_idx_reg <= ch_wide[CH_W-1:0];
                    err_reg    <= err_in;
                    drive_reg  <= $signed(DATA_W'(full_off_reg));
                end
            end
            S_ACC:
            begin
                prod_reg <= prod_v;
                quot_reg <= '0;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    quot_reg <= div_rsp.quotient;
                end
            end
            S_SUM:
            begin
                drive_reg <= drive_v;
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    drive_out_reg <= drive_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // An accepted transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // Divider completion is only seen while waiting for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    // A result appears only from the emit phase
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit phase");
`endif

endmodule : fan_pi_regulator_clamped
`default_nettype wire
